### rtl/kee_pkg.sv
`timescale 1ns / 1ps
// Shared types, character constants and lookup tables for the key event escape encoder.
package kee_pkg;

  localparam int MaxBytes = 12;                  // longest sequence per event
  localparam int IdxW     = $clog2(MaxBytes + 1);
  localparam int DigMax   = 7;                   // decimal digits of a 21-bit code
  localparam int DigCntW  = $clog2(DigMax + 1);
  localparam int KeyW     = 21;

  // q = (v * DivRecip) >> DivShift equals v / 10 for every v below 2**22
  localparam logic [21:0] DivRecip = 22'd3355444;
  localparam int          DivShift = 25;

  typedef enum logic [1:0] {
    CMD_UNICODE  = 2'd0,
    CMD_NAMED    = 2'd1,
    CMD_FUNCTION = 2'd2,
    CMD_OTHER    = 2'd3
  } cmd_t;

  localparam logic [2:0] MOD_NONE = 3'd0;
  localparam logic [2:0] MOD_ALT  = 3'd2;
  localparam logic [2:0] MOD_CTRL = 3'd4;

  // named key indices that bound the key groups
  localparam logic [3:0] KEY_ESCAPE = 4'd3;
  localparam logic [3:0] KEY_DEL    = 4'd5;   // last key of the C0 group
  localparam logic [3:0] KEY_END    = 4'd11;  // last key of the arrow group
  localparam logic [3:0] FUNC_MAX   = 4'd12;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_U        = 8'h75;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_ONE      = 8'h31;

  typedef struct packed {
    cmd_t        cmd;
    logic [20:0] key_code;
    logic [2:0]  modifiers;
    logic [31:0] utf8_bytes;
    logic [2:0]  utf8_length;
  } item_t;

  // decimal digits of the key code, most significant in digits[0]
  typedef struct packed {
    logic [DigMax-1:0][3:0] digits;
    logic [DigCntW-1:0]     count;
    logic                   done;
  } dec_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [IdxW-1:0]          len;
  } seq_t;

  // short decimal string, first character in chars[0]
  typedef struct packed {
    logic [2:0][7:0] chars;
    logic [1:0]      len;
  } dnum_t;

  function automatic logic [7:0] c0_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h08;
      4'd1:    b = 8'h09;
      4'd2:    b = 8'h0D;
      4'd3:    b = 8'h1B;
      4'd4:    b = 8'h20;
      4'd5:    b = 8'h7F;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // decimal text of the C0 byte of a named key
  function automatic dnum_t c0_dec(input logic [3:0] idx);
    dnum_t d;
    unique case (idx)
      4'd0:    d = '{chars: 24'h000038, len: 2'd1};  // 8
      4'd1:    d = '{chars: 24'h000039, len: 2'd1};  // 9
      4'd2:    d = '{chars: 24'h003331, len: 2'd2};  // 13
      4'd3:    d = '{chars: 24'h003732, len: 2'd2};  // 27
      4'd4:    d = '{chars: 24'h003233, len: 2'd2};  // 32
      4'd5:    d = '{chars: 24'h373231, len: 2'd3};  // 127
      default: d = '{chars: 24'h000000, len: 2'd0};
    endcase
    return d;
  endfunction

  function automatic logic [7:0] arrow_letter(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd6:    b = 8'h41;  // up
      4'd7:    b = 8'h42;  // down
      4'd8:    b = 8'h44;  // left
      4'd9:    b = 8'h43;  // right
      4'd10:   b = 8'h48;  // home
      4'd11:   b = 8'h46;  // end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] special_digit(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd12:   b = 8'h32;  // insert
      4'd13:   b = 8'h33;  // delete
      4'd14:   b = 8'h35;  // page up
      4'd15:   b = 8'h36;  // page down
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // two-digit tilde code of F1..F12, first character in the low byte
  function automatic logic [15:0] func_dec(input logic [3:0] num);
    logic [15:0] s;
    unique case (num)
      4'd1:    s = 16'h3131;
      4'd2:    s = 16'h3231;
      4'd3:    s = 16'h3331;
      4'd4:    s = 16'h3431;
      4'd5:    s = 16'h3531;
      4'd6:    s = 16'h3731;
      4'd7:    s = 16'h3831;
      4'd8:    s = 16'h3931;
      4'd9:    s = 16'h3032;
      4'd10:   s = 16'h3132;
      4'd11:   s = 16'h3332;
      4'd12:   s = 16'h3432;
      default: s = 16'h0000;
    endcase
    return s;
  endfunction

endpackage

### rtl/kee_dec_conv.sv
`timescale 1ns / 1ps
// Iterative binary to decimal converter for the key code, one digit per cycle.
module kee_dec_conv import kee_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic            need,
  input  logic [KeyW-1:0] code,
  output dec_t            dec
);

  localparam int ProdW = KeyW + $bits(DivRecip);
  localparam int QW    = ProdW - DivShift;

  logic [KeyW-1:0]        v;
  logic [DigMax-1:0][3:0] digits;
  logic [DigCntW-1:0]     count;
  logic                   done;

  logic [ProdW-1:0] prod;
  logic [QW-1:0]    q;
  logic [KeyW-1:0]  rem_full;

  // divide by ten through the reciprocal, remainder by subtracting 8q + 2q
  assign prod     = ProdW'(v) * ProdW'(DivRecip);
  assign q        = prod[ProdW-1:DivShift];
  assign rem_full = v - (KeyW'({q, 3'b000}) + KeyW'({q, 1'b0}));

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b1;
      count <= '0;
    end else if (load) begin
      done  <= ~need;
      count <= '0;
    end else if (!done) begin
      count <= count + DigCntW'(1);
      done  <= (q == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      v <= code;
    end else if (!done) begin
      v      <= KeyW'(q);
      digits <= {digits[DigMax-2:0], rem_full[3:0]};
    end
  end

  assign dec = '{digits: digits, count: count, done: done};

endmodule

### rtl/kee_seq_build.sv
`timescale 1ns / 1ps
// Combinational assembly of the escape sequence for one key event.
module kee_seq_build import kee_pkg::*; (
  input  item_t item,
  input  dec_t  dec,
  output seq_t  seq
);

  localparam logic [KeyW-1:0] LowA   = KeyW'(8'h61);
  localparam logic [KeyW-1:0] LowZ   = KeyW'(8'h7A);
  localparam logic [KeyW-1:0] CaseOf = KeyW'(8'h20);
  localparam logic [KeyW-1:0] CtlLo  = KeyW'(8'h40);
  localparam logic [KeyW-1:0] CtlHi  = KeyW'(8'h5F);
  localparam logic [KeyW-1:0] LetH   = KeyW'(8'h48);
  localparam logic [KeyW-1:0] LetI   = KeyW'(8'h49);
  localparam logic [KeyW-1:0] LetM   = KeyW'(8'h4D);
  localparam logic [KeyW-1:0] LetBr  = KeyW'(8'h5B);
  localparam int              SeqW   = MaxBytes * 8;

  logic [3:0]              idx;
  logic                    idx_hi;
  logic [2:0]              mods;
  logic [7:0]              mod_char;
  logic [2:0]              utf8_n;
  logic [DigMax-1:0][7:0]  utf8_body;
  logic [DigMax-1:0][7:0]  num_body;
  logic [KeyW-1:0]         ctrl_u;
  logic                    ctrl_ok;
  logic [7:0]              c0b;
  dnum_t                   c0d;
  logic [15:0]             fnum;

  logic [1:0][7:0]         head;
  logic [DigMax-1:0][7:0]  body;
  logic [DigMax-1:0][7:0]  body_m;
  logic [2:0][7:0]         tail;
  logic [1:0]              hl;
  logic [DigCntW-1:0]      bl;
  logic [1:0]              tl;
  logic [IdxW-1:0]         hb_len;
  logic [IdxW-1:0]         total;
  logic [SeqW-1:0]         seq_bits;

  assign idx       = item.key_code[3:0];
  assign idx_hi    = (item.key_code[KeyW-1:4] != '0);
  assign mods      = item.modifiers;
  assign mod_char  = CH_ONE + {5'b00000, mods};
  assign utf8_n    = (item.utf8_length > 3'd4) ? 3'd4 : item.utf8_length;
  assign utf8_body = {24'h000000, item.utf8_bytes};
  assign c0b       = c0_byte(idx);
  assign c0d       = c0_dec(idx);
  assign fnum      = func_dec(idx);

  // lower-case letters fold to upper case for the Ctrl test only
  assign ctrl_u  = (item.key_code >= LowA && item.key_code <= LowZ) ?
                   item.key_code - CaseOf : item.key_code;
  assign ctrl_ok = (ctrl_u >= CtlLo) && (ctrl_u <= CtlHi) && (ctrl_u != LetH) &&
                   (ctrl_u != LetI) && (ctrl_u != LetM) && (ctrl_u != LetBr);

  always_comb begin
    for (int i = 0; i < DigMax; i++) begin
      num_body[i] = CH_ZERO | {4'h0, dec.digits[i]};
    end
  end

  always_comb begin
    head = '0;
    body = '0;
    tail = '0;
    hl   = '0;
    bl   = '0;
    tl   = '0;
    unique case (item.cmd)
      CMD_UNICODE: begin
        if (mods == MOD_NONE) begin
          body = utf8_body;
          bl   = DigCntW'(utf8_n);
        end else if (mods == MOD_CTRL && ctrl_ok) begin
          body[0] = {3'b000, ctrl_u[4:0]};
          bl      = DigCntW'(1);
        end else if (mods == MOD_ALT) begin
          head[0] = CH_ESC;
          hl      = 2'd1;
          body    = utf8_body;
          bl      = DigCntW'(utf8_n);
        end else begin
          head    = {CH_LBRACKET, CH_ESC};
          hl      = 2'd2;
          body    = num_body;
          bl      = dec.count;
          tail    = {CH_U, mod_char, CH_SEMI};
          tl      = 2'd3;
        end
      end
      CMD_NAMED: begin
        if (idx_hi) begin
          // unknown key: nothing
        end else if (idx == KEY_ESCAPE ||
                     (idx <= KEY_DEL && mods != MOD_NONE && mods != MOD_ALT)) begin
          head = {CH_LBRACKET, CH_ESC};
          hl   = 2'd2;
          body = (DigMax*8)'(c0d.chars);
          bl   = DigCntW'(c0d.len);
          tail = {CH_U, mod_char, CH_SEMI};
          tl   = 2'd3;
        end else if (idx <= KEY_DEL) begin
          if (mods == MOD_ALT) begin
            head[0] = CH_ESC;
            hl      = 2'd1;
          end
          body[0] = c0b;
          bl      = DigCntW'(1);
        end else if (idx <= KEY_END) begin
          head = {CH_LBRACKET, CH_ESC};
          hl   = 2'd2;
          if (mods != MOD_NONE) begin
            body[0] = CH_ONE;
            body[1] = CH_SEMI;
            body[2] = mod_char;
            bl      = DigCntW'(3);
          end
          tail[0] = arrow_letter(idx);
          tl      = 2'd1;
        end else begin
          head    = {CH_LBRACKET, CH_ESC};
          hl      = 2'd2;
          body[0] = special_digit(idx);
          bl      = DigCntW'(1);
          if (mods != MOD_NONE) begin
            tail = {CH_TILDE, mod_char, CH_SEMI};
            tl   = 2'd3;
          end else begin
            tail[0] = CH_TILDE;
            tl      = 2'd1;
          end
        end
      end
      CMD_FUNCTION: begin
        if (!idx_hi && idx != 4'd0 && idx <= FUNC_MAX) begin
          head    = {CH_LBRACKET, CH_ESC};
          hl      = 2'd2;
          body[0] = fnum[7:0];
          body[1] = fnum[15:8];
          bl      = DigCntW'(2);
          if (mods != MOD_NONE) begin
            tail = {CH_TILDE, mod_char, CH_SEMI};
            tl   = 2'd3;
          end else begin
            tail[0] = CH_TILDE;
            tl      = 2'd1;
          end
        end
      end
      CMD_OTHER: begin
        // no encoding
      end
    endcase
  end

  // clear body bytes past its length so the tail lands on zeros
  always_comb begin
    for (int i = 0; i < DigMax; i++) begin
      body_m[i] = (DigCntW'(i) < bl) ? body[i] : 8'h00;
    end
  end

  assign hb_len   = IdxW'(hl) + IdxW'(bl);
  assign total    = hb_len + IdxW'(tl);
  assign seq_bits = SeqW'(head) | (SeqW'(body_m) << {hl, 3'b000}) |
                    (SeqW'(tail) << {hb_len, 3'b000});

  always_comb begin
    seq.len = total;
    for (int i = 0; i < MaxBytes; i++) begin
      seq.bytes[i] = (IdxW'(i) < total) ? seq_bits[i*8 +: 8] : 8'h00;
    end
  end

endmodule

### rtl/key_event_escape_encoder.sv
`timescale 1ns / 1ps
// Top level of the key event escape encoder: input stage, decimal converter, byte serializer.
//
// Usage:
//   s_axis carries one key event per transfer; m_axis returns the terminal byte
//   sequence for it, one byte per transfer, with tlast on the final byte. A key
//   with no encoding gives a single zero byte with tuser (no_sequence) set.
//   The first byte is presented once the event has moved from the input stage
//   register into the serializer, and can transfer from then on.
//   Unicode events that take the CSI-u form run the key code through a
//   one-digit-per-cycle decimal converter first, for 1 to 7 digits, before
//   the event can move on. Throughput: one byte per cycle on m_axis while
//   m_axis_tready is high; an event gives 1 to 12 bytes, and the next sequence
//   follows its last byte with no gap, as long as the next event's digits
//   are ready when the current sequence ends. The input stage accepts and
//   converts the next event while the current sequence is still draining.
//   Reset (rst, synchronous) empties both stages; no transfer is in flight
//   afterwards. When the receiver holds m_axis_tready low, the current byte
//   holds, the input stage fills and s_axis_tready drops until it moves on.
module key_event_escape_encoder import kee_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // key_code [20:0], modifiers [23:21], utf8_bytes [55:24], utf8_length [58:56]
  input  logic [63:0] s_axis_tdata,
  // cmd [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte [7:0]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  // no_sequence [0]
  output logic        m_axis_tuser
);

  item_t in_item;
  logic  in_xfer;
  logic  need_conv;

  // input stage
  logic  a_valid;
  item_t a_item;
  logic  a_move;

  // decimal digits of the held key code
  dec_t  dec;

  // assembled sequence
  seq_t  seq;

  // output serializer
  logic                     b_valid;
  logic [MaxBytes-1:0][7:0] b_buf;
  logic [IdxW-1:0]          b_len;
  logic [IdxW-1:0]          b_idx;
  logic                     b_empty;
  logic                     out_xfer;
  logic                     out_done;
  logic                     b_free;

  assign in_item = '{cmd:         cmd_t'(s_axis_tuser),
                     key_code:    s_axis_tdata[20:0],
                     modifiers:   s_axis_tdata[23:21],
                     utf8_bytes:  s_axis_tdata[55:24],
                     utf8_length: s_axis_tdata[58:56]};

  // only the Unicode CSI-u form needs the code in decimal
  assign need_conv = (in_item.cmd == CMD_UNICODE) && (in_item.modifiers != MOD_NONE) &&
                     (in_item.modifiers != MOD_ALT);

  assign out_xfer      = m_axis_tvalid & m_axis_tready;
  assign out_done      = out_xfer & m_axis_tlast;
  assign b_free        = ~b_valid | out_done;
  assign a_move        = a_valid & dec.done & b_free;
  assign s_axis_tready = ~a_valid | a_move;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  kee_dec_conv u_dec (
    .clk  (clk),
    .rst  (rst),
    .load (in_xfer),
    .need (need_conv),
    .code (in_item.key_code),
    .dec  (dec)
  );

  kee_seq_build u_build (
    .item (a_item),
    .dec  (dec),
    .seq  (seq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        a_valid <= 1'b1;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
      if (a_move) begin
        b_valid <= 1'b1;
      end else if (out_done) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_item <= in_item;
    end
    if (a_move) begin
      // an empty sequence still sends one zero byte, flagged
      b_buf   <= seq.bytes;
      b_len   <= (seq.len == '0) ? IdxW'(1) : seq.len;
      b_empty <= (seq.len == '0);
      b_idx   <= '0;
    end else if (out_xfer) begin
      b_idx <= b_idx + IdxW'(1);
    end
  end

  assign m_axis_tvalid = b_valid;
  assign m_axis_tdata  = b_buf[b_idx];
  assign m_axis_tlast  = (b_idx == b_len - IdxW'(1));
  assign m_axis_tuser  = b_empty;

`ifndef SYNTH
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b_idx < b_len) && (b_len <= IdxW'(MaxBytes)))
    else $error("serializer index past sequence length");

  a_empty_single: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_empty) |-> (m_axis_tlast && m_axis_tdata == 8'h00))
    else $error("empty result is not a single zero byte");

  a_no_conv_ready: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !need_conv) |=> dec.done)
    else $error("converter busy on an event that needs no digits");

  a_load_restart: assert property (@(posedge clk) disable iff (rst)
    a_move |=> (b_valid && b_idx == '0))
    else $error("serializer did not restart on a new sequence");
`endif

endmodule
